// ===== rtl/dpagc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpagc_pkg
// Types and constants shared by the decimating peak AGC scaler.
// ----------------------------------------------------------------------------
package dpagc_pkg;

    // Input request: one inverse FFT output sample
    typedef struct packed {
        logic signed [31:0] sample;
        logic               frame_start;
    } dpagc_req_t;

    // Result request: one scaled audio sample
    typedef struct packed {
        logic signed [14:0] audio;
        logic               last_of_block;
    } dpagc_resp_t;

    // Configuration register indexes
    localparam logic [1:0] REG_AUDIO_ENABLE = 2'd0;
    localparam logic [1:0] REG_DECIM_STEP   = 2'd1;
    localparam logic [1:0] REG_BLOCK_LENGTH = 2'd2;
    localparam logic [1:0] REG_DECAY_AMOUNT = 2'd3;

    localparam int unsigned CFG_DATA_W = 17;

    // Reset values of the configuration registers
    localparam logic [10:0] DECIM_STEP_RST   = 11'd4;
    localparam logic [16:0] BLOCK_LENGTH_RST = 17'd8000;
    localparam logic [15:0] DECAY_AMOUNT_RST = 16'd100;

    // Clamp limits
    localparam logic [10:0] MAX_DECIM = 11'd1024;
    localparam logic [16:0] MAX_BLOCK = 17'd65536;

    // Scaling: audio = sample * (2^15 - 1) / (3 * peak); the quotient stays
    // below 2^14 because |sample| never exceeds peak.
    localparam int unsigned FULL_SCALE_SHIFT = 15;
    localparam int unsigned QUOT_BITS        = 14;
    localparam int signed   AUDIO_LIMIT      = 10922;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } dpagc_state_t;

endpackage

// ===== rtl/decimating_peak_agc_scaler_core.sv =====
// ----------------------------------------------------------------------------
// decimating_peak_agc_scaler_core
// A kept sample passes through magnitude, operand load, 14 restoring-division
//   steps (one quotient bit per cycle) and output.
// No new request is taken until a kept sample's result enters the output
//   register; dropped samples and requests while disabled leave the block idle.
// Reset (aresetn, synchronous, active low): peak = 1, phase and block count
//   cleared, registers at enable 0, step 4, block length 8000, decay 100.
// ----------------------------------------------------------------------------
module decimating_peak_agc_scaler_core
    import dpagc_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // input requests
    input  logic                  s_valid,
    output logic                  s_ready,
    input  dpagc_req_t            s_req,

    // result requests
    output logic                  m_valid,
    input  logic                  m_ready,
    output dpagc_resp_t           m_resp
);

    localparam int unsigned SW = SAMPLE_WIDTH;
    // numerator / shifted divisor width: N = mag * 32767 < 2^(SW+14)
    localparam int unsigned NW = SW + QUOT_BITS;
    // sign-extended view of the 32-bit sample field
    localparam int unsigned XW = (SW > 32) ? SW : 32;
    // compare width for the decay floor test
    localparam int unsigned CW = ((SW > 17) ? SW : 17) + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        audio_enable_reg;
    logic [10:0] decim_step_reg;
    logic [16:0] block_length_reg;
    logic [15:0] decay_amount_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            audio_enable_reg <= 1'b0;
            decim_step_reg   <= DECIM_STEP_RST;
            block_length_reg <= BLOCK_LENGTH_RST;
            decay_amount_reg <= DECAY_AMOUNT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_AUDIO_ENABLE: audio_enable_reg <= cfg_data[0];
                REG_DECIM_STEP:   decim_step_reg   <= cfg_data[10:0];
                REG_BLOCK_LENGTH: block_length_reg <= cfg_data[16:0];
                REG_DECAY_AMOUNT: decay_amount_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Effective step and block length: zero acts as one, big values clamp.
    logic [10:0] eff_step;
    logic [16:0] eff_block;

    always_comb begin
        if (decim_step_reg == 11'd0) begin
            eff_step = 11'd1;
        end else if (decim_step_reg > MAX_DECIM) begin
            eff_step = MAX_DECIM;
        end else begin
            eff_step = decim_step_reg;
        end
        if (block_length_reg == 17'd0) begin
            eff_block = 17'd1;
        end else if (block_length_reg > MAX_BLOCK) begin
            eff_block = MAX_BLOCK;
        end else begin
            eff_block = block_length_reg;
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    dpagc_state_t state_reg, state_next;

    logic          in_fire;
    logic          out_load;
    logic          m_valid_reg;
    dpagc_resp_t   m_resp_reg;

    logic [9:0]    decim_phase_reg;
    logic [16:0]   block_count_reg;
    logic [SW-1:0] peak_reg;

    // Datapath registers (no reset needed)
    logic [SW-1:0] raw_reg;
    logic [SW-1:0] mag_reg;
    logic          neg_reg;
    logic          last_reg;
    logic [NW-1:0] rem_reg;
    logic [NW-1:0] den_reg;
    logic [QUOT_BITS-1:0] quot_reg;
    logic [3:0]    bit_cnt_reg;

    assign in_fire  = s_valid && s_ready;
    // the output register takes the result once it is empty or draining
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // ------------------------------------------------------------------
    // Phase and block counting, resolved at request acceptance
    // ------------------------------------------------------------------
    logic [9:0]  phase_start;
    logic [10:0] phase_inc;
    logic        keep;
    logic [9:0]  decim_phase_next;
    logic [16:0] count_inc;
    logic        last_next;

    always_comb begin
        phase_start      = s_req.frame_start ? 10'd0 : decim_phase_reg;
        keep             = (phase_start == 10'd0);
        phase_inc        = {1'b0, phase_start} + 11'd1;
        decim_phase_next = (phase_inc >= eff_step) ? 10'd0 : phase_inc[9:0];
        count_inc        = block_count_reg + 17'd1;
        last_next        = (count_inc >= eff_block);
    end

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && audio_enable_reg && keep) begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV: begin
                if (bit_cnt_reg == 4'd0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Output logic
    // ------------------------------------------------------------------
    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = m_valid_reg;
        m_resp  = m_resp_reg;
    end

    // ------------------------------------------------------------------
    // Arithmetic
    // ------------------------------------------------------------------
    logic [XW-1:0]   sample_ext;
    logic [SW-1:0]   mag_calc;
    logic [SW+14:0]  num_full;
    logic [SW+1:0]   den3;
    logic [SW+14:0]  den_full;
    logic [CW-1:0]   decay_limit;
    logic [SW-1:0]   peak_decayed;
    logic            div_ge;
    logic [14:0]     quot_ext;
    logic [14:0]     audio_calc;

    always_comb begin
        // low SAMPLE_WIDTH bits of the sample, two's complement
        sample_ext = XW'(s_req.sample);
        if (XW > 32) begin
            sample_ext = XW'($signed(s_req.sample));
        end
        // |x|; the most negative code maps to 2^(SW-1) on its own
        mag_calc = raw_reg[SW-1] ? (~raw_reg + SW'(1)) : raw_reg;
        // mag * 32767 as (mag << 15) - mag
        num_full = {mag_reg, {FULL_SCALE_SHIFT{1'b0}}} -
                   {{FULL_SCALE_SHIFT{1'b0}}, mag_reg};
        // 3 * peak, aligned for the first quotient bit
        den3     = {1'b0, peak_reg, 1'b0} + {2'b00, peak_reg};
        den_full = {den3, {(QUOT_BITS - 1){1'b0}}};
        // linear decay with a floor of 1
        decay_limit = CW'(decay_amount_reg) + CW'(1);
        if (CW'(peak_reg) > decay_limit) begin
            peak_decayed = peak_reg - SW'(decay_amount_reg);
        end else begin
            peak_decayed = SW'(1);
        end
        div_ge     = (rem_reg >= den_reg);
        quot_ext   = {1'b0, quot_reg};
        audio_calc = neg_reg ? (15'd0 - quot_ext) : quot_ext;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            decim_phase_reg <= 10'd0;
            block_count_reg <= 17'd0;
            peak_reg        <= SW'(1);
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            // disabled: request is dropped with no state change
            if (in_fire && audio_enable_reg) begin
                decim_phase_reg <= decim_phase_next;
                if (keep) begin
                    block_count_reg <= last_next ? 17'd0 : count_inc;
                end
            end

            case (state_reg)
                ST_MAG: begin
                    if (mag_calc > peak_reg) begin
                        peak_reg <= mag_calc;
                    end
                end
                ST_LOAD: peak_reg <= peak_decayed;
                default: ;
            endcase

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            raw_reg  <= sample_ext[SW-1:0];
            last_reg <= last_next;
        end
        case (state_reg)
            ST_MAG: begin
                mag_reg <= mag_calc;
                neg_reg <= raw_reg[SW-1];
            end
            ST_LOAD: begin
                rem_reg     <= num_full[NW-1:0];
                den_reg     <= den_full[NW-1:0];
                quot_reg    <= '0;
                bit_cnt_reg <= 4'(QUOT_BITS - 1);
            end
            ST_DIV: begin
                // restoring division, one quotient bit per cycle
                if (div_ge) begin
                    rem_reg <= rem_reg - den_reg;
                end
                quot_reg    <= {quot_reg[QUOT_BITS-2:0], div_ge};
                den_reg     <= den_reg >> 1;
                bit_cnt_reg <= bit_cnt_reg - 4'd1;
            end
            default: ;
        endcase
        if (out_load) begin
            m_resp_reg.audio         <= audio_calc;
            m_resp_reg.last_of_block <= last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // peak never reaches zero, so the divisor is never zero
    a_peak_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg != '0)
        else $error("peak register reached zero");

    // partial remainder stays below twice the current divisor step
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> {1'b0, rem_reg} < {den_reg, 1'b0})
        else $error("divider remainder out of range");

    // audio stays within the scaled range
    a_audio_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ($signed(m_resp_reg.audio) <= 15'sd10922 &&
                         $signed(m_resp_reg.audio) >= -15'sd10922))
        else $error("audio sample out of range");

    // no new request is taken while a sample is being scaled
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV || state_reg == ST_DONE) |=> !$past(in_fire))
        else $error("request accepted while busy");

endmodule

// ===== tb/sv/dpagc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dpagc_checker
// Watches the configuration port and both request channels of the scaler,
// predicts each audio request from the accepted input requests, and checks
// every result request against the oldest prediction.
// ----------------------------------------------------------------------------
module dpagc_checker
    import dpagc_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  dpagc_req_t            s_req,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  dpagc_resp_t           m_resp,
    output int unsigned           fail_count,
    output int unsigned           pending
);

    // shadow registers
    logic        audio_on;
    logic [10:0] decim_step_r;
    logic [16:0] block_len_r;
    logic [15:0] decay_r;

    // shadow state
    logic [SAMPLE_WIDTH-1:0] peak;
    logic [9:0]              phase;
    logic [16:0]             block_cnt;

    dpagc_resp_t expected_audio_q[$];
    int unsigned mismatches = 0;

    task automatic report_mismatch(input string what);
        $display("@%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic predict_audio(input dpagc_req_t req);
        logic [10:0]             step;
        logic [10:0]             next_phase;
        logic [16:0]             len;
        logic                    kept;
        logic                    neg;
        logic [SAMPLE_WIDTH-1:0] raw;
        logic [SAMPLE_WIDTH-1:0] mag;
        logic [63:0]             quo;
        logic [14:0]             q15;
        dpagc_resp_t             res;
        if (!audio_on)
            return;
        step = (decim_step_r == '0)       ? 11'd1 :
               (decim_step_r > MAX_DECIM) ? MAX_DECIM : decim_step_r;
        if (req.frame_start)
            phase = '0;
        kept       = (phase == '0);
        next_phase = {1'b0, phase} + 11'd1;
        phase      = (next_phase >= step) ? 10'd0 : next_phase[9:0];
        if (!kept)
            return;

        raw = req.sample[SAMPLE_WIDTH-1:0];
        neg = raw[SAMPLE_WIDTH-1];
        mag = neg ? -raw : raw;     // most negative input stays 2^(W-1)
        if (mag > peak)
            peak = mag;
        if (peak == '0)
            peak = SAMPLE_WIDTH'(1);

        quo = (64'(mag) * 64'd32767) / (64'(peak) * 64'd3);
        q15 = quo[14:0];
        res.audio = neg ? -q15 : q15;

        // linear decay, floored at 1
        if (peak > SAMPLE_WIDTH'(1)) begin
            if (64'(peak) > 64'(decay_r) + 64'd1)
                peak = peak - SAMPLE_WIDTH'(decay_r);
            else
                peak = SAMPLE_WIDTH'(1);
        end

        len = (block_len_r == '0)       ? 17'd1 :
              (block_len_r > MAX_BLOCK) ? MAX_BLOCK : block_len_r;
        block_cnt = block_cnt + 17'd1;
        res.last_of_block = (block_cnt >= len);
        if (res.last_of_block)
            block_cnt = '0;
        expected_audio_q.push_back(res);
    endtask

    task automatic check_audio(input dpagc_resp_t got);
        dpagc_resp_t want;
        if (expected_audio_q.size() == 0) begin
            report_mismatch($sformatf("unexpected audio %0d last %0b",
                                      got.audio, got.last_of_block));
            return;
        end
        want = expected_audio_q.pop_front();
        if (got.audio !== want.audio)
            report_mismatch($sformatf("audio got %0d expected %0d",
                                      got.audio, want.audio));
        if (got.last_of_block !== want.last_of_block)
            report_mismatch($sformatf("last_of_block got %0b expected %0b",
                                      got.last_of_block, want.last_of_block));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            audio_on     = 1'b0;
            decim_step_r = DECIM_STEP_RST;
            block_len_r  = BLOCK_LENGTH_RST;
            decay_r      = DECAY_AMOUNT_RST;
            peak         = SAMPLE_WIDTH'(1);
            phase        = '0;
            block_cnt    = '0;
            expected_audio_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_AUDIO_ENABLE: audio_on     = cfg_data[0];
                    REG_DECIM_STEP:   decim_step_r = cfg_data[10:0];
                    REG_BLOCK_LENGTH: block_len_r  = cfg_data[16:0];
                    REG_DECAY_AMOUNT: decay_r      = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready)
                check_audio(m_resp);
            if (s_valid && s_ready)
                predict_audio(s_req);
        end
        pending    <= expected_audio_q.size();
        fail_count <= mismatches;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the decimating peak AGC scaler. A directed pass
// covers field extremes, disabled audio, step and block clamping, floor of
// the peak decay and a block length lowered under the running count; then
// random phases of framed samples run under random configurations, with
// random idle gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
    import dpagc_pkg::*;

    localparam int unsigned SAMPLE_W      = 32;
    localparam int unsigned RANDOM_ITEMS  = 1100;
    // leave some margin after the last result before touching config
    localparam int unsigned SETTLE_CYCLES = 24;
    // watchdog limit for the whole run
    localparam int unsigned CYCLE_LIMIT   = 400000;

    // register select masks for configure()
    localparam logic [3:0] CFG_ALL      = 4'b1111;
    localparam logic [3:0] CFG_EN_ONLY  = 4'(1) << REG_AUDIO_ENABLE;
    localparam logic [3:0] CFG_LEN_ONLY = 4'(1) << REG_BLOCK_LENGTH;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [1:0]            cfg_index = REG_AUDIO_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    dpagc_req_t            s_req     = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    dpagc_resp_t           m_resp;

    int unsigned fail_count;
    int unsigned pending_audio;
    int unsigned cycle_count = 0;

    // per-phase switches that turn idling off on either side
    bit          tx_calm = 1'b0;
    bit          rx_calm = 1'b0;
    int unsigned rx_hold = 0;
    int unsigned stall_draw;

    initial begin
        forever #5 aclk = ~aclk;
    end

    decimating_peak_agc_scaler_core #(
        .SAMPLE_WIDTH (SAMPLE_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_resp    (m_resp)
    );

    dpagc_checker #(
        .SAMPLE_WIDTH (SAMPLE_W)
    ) audio_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_resp     (m_resp),
        .fail_count (fail_count),
        .pending    (pending_audio)
    );

    // Result side: after each accepted request draw a random stall.
    // Ready may sit high with nothing to take; that is legal.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (m_ready) begin
            if (m_valid) begin
                stall_draw = rx_calm ? 0 : $urandom_range(0, 13);
                m_ready <= (stall_draw == 0);
                rx_hold <= stall_draw;
            end
        end else if (rx_hold <= 1) begin
            m_ready <= 1'b1;
            rx_hold <= 0;
        end else begin
            rx_hold <= rx_hold - 1;
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Input side: optional idle gap, then hold the request until taken.
    // Valid is only dropped when a gap follows, so back-to-back requests
    // never see a low/high pair in the same time step.
    task automatic send_item(input logic signed [31:0] smp, input logic fs);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= {smp, fs};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Wait until every predicted result is back, then let any dropped
    // sample still in the pipe clear before config may change.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_audio != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the selected registers, one per cycle, while the block is idle.
    task automatic configure(input logic [3:0] sel, input logic en,
                             input logic [10:0] step, input logic [16:0] len,
                             input logic [15:0] decay);
        int idx;
        for (idx = 0; idx < 4; idx++) begin
            if (sel[idx]) begin
                cfg_wr_en <= 1'b1;
                cfg_index <= 2'(idx);
                case (2'(idx))
                    REG_AUDIO_ENABLE: cfg_data <= CFG_DATA_W'(en);
                    REG_DECIM_STEP:   cfg_data <= CFG_DATA_W'(step);
                    REG_BLOCK_LENGTH: cfg_data <= CFG_DATA_W'(len);
                    default:          cfg_data <= CFG_DATA_W'(decay);
                endcase
                @(posedge aclk);
            end
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int unsigned          counted;
        int unsigned          n_items;
        int unsigned          frame_left;
        int unsigned          k;
        logic [3:0]           sel;
        logic                 en;
        logic [10:0]          step;
        logic [16:0]          len;
        logic [15:0]          decay;
        logic signed [31:0]   smp;
        logic                 fs;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed ------------------------------------------------------
        // Audio still disabled from reset: requests are swallowed.
        send_item(32'sd123, 1'b1);
        send_item(-32'sd5, 1'b0);
        drain();

        // Enable only; step 4 / decay 100 come from reset. No frame start
        // yet, so the phase runs on from reset: keeps 1st and 5th, and the framed 6th.
        configure(CFG_EN_ONLY, 1'b1, '0, '0, '0);
        send_item(32'sd1000, 1'b0);
        send_item(32'sd2, 1'b0);
        send_item(32'sd3, 1'b0);
        send_item(32'sd4, 1'b0);
        send_item(-32'sd7, 1'b0);
        send_item(32'sd50, 1'b1);
        drain();

        // Step 0 acts as 1, length 0 acts as 1, huge decay drives the peak
        // to its floor; then full-scale results with peak at 1.
        configure(CFG_ALL, 1'b1, 11'd0, 17'd0, 16'hFFFF);
        send_item(32'sd3, 1'b0);
        send_item(32'sd0, 1'b0);
        send_item(32'sd1, 1'b1);
        send_item(-32'sd1, 1'b0);
        send_item(32'sd32767, 1'b0);
        drain();

        // Step and length past their clamps, zero decay, sample extremes.
        configure(CFG_ALL, 1'b1, 11'd2047, 17'd131071, 16'd0);
        send_item(32'sh7FFF_FFFF, 1'b1);
        send_item(32'sh8000_0000, 1'b1);
        send_item(-32'sd1, 1'b1);
        send_item(32'sd12345, 1'b0);
        drain();

        // Build up a block count, then cut the length beneath it.
        configure(CFG_ALL, 1'b1, 11'd1, 17'd65536, 16'd100);
        send_item(-32'sd40000, 1'b1);
        send_item(32'sd9999, 1'b0);
        send_item(32'sd77, 1'b1);
        send_item(-32'sd123456, 1'b0);
        drain();
        configure(CFG_LEN_ONLY, 1'b1, '0, 17'd2, '0);
        send_item(32'sd31000, 1'b0);
        drain();

        // ---- random phases -------------------------------------------------
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            en = ($urandom_range(0, 7) != 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: step = 11'($urandom_range(1, 6));
                6:                step = 11'd0;
                7:                step = MAX_DECIM;
                8:                step = 11'($urandom_range(1025, 2047));
                default:          step = 11'($urandom_range(7, 40));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: len = 17'($urandom_range(1, 12));
                6:                len = 17'd0;
                7:                len = MAX_BLOCK;
                8:                len = 17'($urandom_range(65537, 131071));
                default:          len = 17'($urandom_range(13, 300));
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2, 3: decay = 16'($urandom_range(0, 65535));
                4:          decay = 16'd0;
                5:          decay = 16'hFFFF;
                default:    decay = 16'($urandom_range(0, 500));
            endcase
            // enable is always rewritten so each phase knows its mode
            sel     = 4'($urandom_range(0, 7) << 1) | CFG_EN_ONLY;
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            configure(sel, en, step, len, decay);

            n_items    = en ? $urandom_range(60, 200) : $urandom_range(5, 20);
            frame_left = 0;
            for (k = 0; k < n_items; k++) begin
                // mostly proper frames, with the odd stray or missing start
                fs = (frame_left == 0);
                if (fs)
                    frame_left = $urandom_range(1, 48);
                frame_left--;
                if ($urandom_range(0, 11) == 0)
                    fs = ~fs;

                case ($urandom_range(0, 9))
                    0, 1, 2, 3: smp = $urandom;
                    4: begin
                        case ($urandom_range(0, 4))
                            0:       smp = 32'sh7FFF_FFFF;
                            1:       smp = 32'sh8000_0000;
                            2:       smp = 32'sd0;
                            3:       smp = 32'sd1;
                            default: smp = -32'sd1;
                        endcase
                    end
                    default: begin
                        // small magnitudes so the decay actually matters
                        smp = $urandom >> $urandom_range(1, 30);
                        if ($urandom_range(0, 1) != 0)
                            smp = -smp;
                    end
                endcase
                send_item(smp, fs);
            end
            if (en)
                counted += n_items;
            drain();
        end

        if (fail_count == 0 && pending_audio == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
